FILE: rtl/core/rgbds_pkg.sv
package rgbds_pkg;

   // Fixed field and counter widths
   localparam int PIXEL_W    = 16;
   localparam int HEIGHT_W   = 12;
   localparam int ROW_W      = 11;
   localparam int MAX_HEIGHT = 2048;

   // RGB565 channel masks and positions
   localparam logic [4:0] RED_MASK   = 5'h1F;
   localparam logic [5:0] GREEN_MASK = 6'h3F;
   localparam logic [4:0] BLUE_MASK  = 5'h1F;
   localparam int RED_LSB   = 11;
   localparam int GREEN_LSB = 5;

   // Register reset values
   localparam logic [10:0] WIDTH_RESET  = 11'd400;
   localparam logic [11:0] HEIGHT_RESET = 12'd240;

   // Register indexes (byte address / 4)
   typedef enum logic [0:0] {
      REG_SOURCE_WIDTH  = 1'b0,
      REG_SOURCE_HEIGHT = 1'b1
   } reg_index_type;

   // Horizontal or vertical channel sums of a pixel pair
   typedef struct packed {
      logic [5:0] red;
      logic [6:0] green;
      logic [5:0] blue;
   } pair_sum_type;

endpackage

FILE: rtl/core/rgb565_box_downscale_2x2_unit.sv
// Path: odd-row pair sums are registered in stage 1, then averaged into rsp_*.
// Throughput: one source pixel per cycle unless the output stalls; the line
//   store (one port: even rows write, odd rows read) never limits the rate.
// Reset: synchronous, active high; clears counters, held pixel and valid flags,
//   restores source_width 400 and source_height 240. The line store is not
//   cleared and holds nothing meaningful until an even row writes it.
module rgb565_box_downscale_2x2_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] source_pixel
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] scaled_pixel
   output logic        rsp_tlast,   // end_of_line
   output logic        rsp_tuser,   // [0] end_of_frame
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW         = $clog2(MAX_WIDTH);
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int XW         = (WW > 11) ? WW : 11;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int HW         = rgbds_pkg::HEIGHT_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [10:0] source_width_ff;
   logic [11:0] source_height_ff;
   logic        csr_write;
   rgbds_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = rgbds_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= rgbds_pkg::WIDTH_RESET;
         source_height_ff <= rgbds_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rgbds_pkg::REG_SOURCE_WIDTH:  source_width_ff  <= csr_pwdata[10:0];
            rgbds_pkg::REG_SOURCE_HEIGHT: source_height_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rgbds_pkg::REG_SOURCE_WIDTH:  csr_prdata = {21'd0, source_width_ff};
         rgbds_pkg::REG_SOURCE_HEIGHT: csr_prdata = {20'd0, source_height_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Frame geometry in use (clamped)
   // ---------------------------------------------------------------
   logic [XW-1:0] width_ext;
   logic [WW-1:0] width_use;
   logic [WW-1:0] width_even;
   logic [HW-1:0] height_use;
   logic [HW-1:0] height_even;

   always_comb begin
      width_ext = XW'(source_width_ff);
      if (width_ext < XW'(2))
         width_use = WW'(2);
      else if (width_ext > XW'(MAX_WIDTH))
         width_use = WW'(MAX_WIDTH);
      else
         width_use = WW'(width_ext);

      if (source_height_ff < HW'(2))
         height_use = HW'(2);
      else if (source_height_ff > HW'(rgbds_pkg::MAX_HEIGHT))
         height_use = HW'(rgbds_pkg::MAX_HEIGHT);
      else
         height_use = source_height_ff;
   end

   assign width_even  = {width_use[WW-1:1], 1'b0};
   assign height_even = {height_use[HW-1:1], 1'b0};

   // ---------------------------------------------------------------
   // Pipeline handshake
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // Position counters and held pixel
   // ---------------------------------------------------------------
   logic [CW-1:0]                  col_ff, col_in;
   logic [rgbds_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [rgbds_pkg::PIXEL_W-1:0]  held_ff;
   logic [WW-1:0]                  col_next;
   logic [HW-1:0]                  row_next;

   assign col_next = WW'(col_ff) + WW'(1);
   assign row_next = HW'(row_ff) + HW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (col_next >= width_use) begin
         col_in = '0;
         row_in = (row_next >= height_use) ? '0 : rgbds_pkg::ROW_W'(row_next);
      end else begin
         col_in = CW'(col_next);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         held_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (!col_ff[0])
            held_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------
   // Pair sums and block classification
   // ---------------------------------------------------------------
   rgbds_pkg::pair_sum_type pair_sum;
   logic          pair_done;
   logic          even_row_pair;
   logic          odd_row_pair;
   logic [AW-1:0] line_idx;
   logic          is_eol;
   logic          is_eof;

   always_comb begin
      pair_sum.red   = {1'b0, held_ff[rgbds_pkg::RED_LSB +: 5] & rgbds_pkg::RED_MASK}
                     + {1'b0, req_tdata[rgbds_pkg::RED_LSB +: 5] & rgbds_pkg::RED_MASK};
      pair_sum.green = {1'b0, held_ff[rgbds_pkg::GREEN_LSB +: 6] & rgbds_pkg::GREEN_MASK}
                     + {1'b0, req_tdata[rgbds_pkg::GREEN_LSB +: 6] & rgbds_pkg::GREEN_MASK};
      pair_sum.blue  = {1'b0, held_ff[4:0] & rgbds_pkg::BLUE_MASK}
                     + {1'b0, req_tdata[4:0] & rgbds_pkg::BLUE_MASK};
   end

   // second pixel of a pair inside the even-sized area
   assign pair_done     = col_ff[0] && (WW'(col_ff) < width_even)
                       && (HW'(row_ff) < height_even);
   assign even_row_pair = pair_done && !row_ff[0];
   assign odd_row_pair  = pair_done && row_ff[0];
   assign line_idx      = AW'(col_ff >> 1);
   assign is_eol        = (WW'(col_ff >> 1) == ((width_use >> 1) - WW'(1)));
   assign is_eof        = is_eol && (HW'(row_ff >> 1) == ((height_use >> 1) - HW'(1)));

   // ---------------------------------------------------------------
   // Line store: even rows write pair sums, odd rows read them
   // ---------------------------------------------------------------
   rgbds_pkg::pair_sum_type line_mem [LINE_DEPTH];
   rgbds_pkg::pair_sum_type line_rd_ff;

   always_ff @(posedge clock) begin
      if (accept && even_row_pair)
         line_mem[line_idx] <= pair_sum;
      if (accept && odd_row_pair)
         line_rd_ff <= line_mem[line_idx];
   end

   // ---------------------------------------------------------------
   // Stage 1: odd-row pair sums waiting for the stored line sums
   // ---------------------------------------------------------------
   rgbds_pkg::pair_sum_type s1_sum_ff;
   logic s1_eol_ff;
   logic s1_eof_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (accept)
         s1_valid_ff <= odd_row_pair;
      else if (advance)
         s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept && odd_row_pair) begin
         s1_sum_ff <= pair_sum;
         s1_eol_ff <= is_eol;
         s1_eof_ff <= is_eof;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: four-sample average into the output register
   // ---------------------------------------------------------------
   logic [6:0] red_total;
   logic [7:0] green_total;
   logic [6:0] blue_total;
   logic [15:0] scaled_in;
   logic [15:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_user_ff;

   assign red_total   = {1'b0, s1_sum_ff.red}   + {1'b0, line_rd_ff.red};
   assign green_total = {1'b0, s1_sum_ff.green} + {1'b0, line_rd_ff.green};
   assign blue_total  = {1'b0, s1_sum_ff.blue}  + {1'b0, line_rd_ff.blue};
   assign scaled_in   = {red_total[6:2], green_total[7:2], blue_total[6:2]};

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= scaled_in;
         rsp_last_ff <= s1_eol_ff;
         rsp_user_ff <= s1_eof_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // end of frame is always also end of line
   a_eof_has_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff |-> rsp_last_ff)
      else $error("end of frame without end of line");

   // a full stage 1 that cannot move on blocks new input
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while pipeline is stalled");

   // a new result only comes from a filled stage 1
   a_result_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a stage 1 item");

endmodule
